### design/moi_pkg.sv
// Shared types and constants of the mecanum odometry integrator.
// No dependencies; every other design file depends on this package.
package moi_pkg;

   // Configuration port
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_X         = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_Y         = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_METERS_PER_TICK = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INV_BASE_WIDTH  = 8'd3;

   localparam logic [31:0] RST_SCALE_X         = 32'd3486560;
   localparam logic [31:0] RST_SCALE_Y         = 32'd2776290;
   localparam logic [31:0] RST_METERS_PER_TICK = 32'd1758720;
   localparam logic [31:0] RST_INV_BASE_WIDTH  = 32'd55188152;

   // Arithmetic constants
   localparam logic [63:0] DELTA_LIMIT     = 64'h2000_0000_0000_0000;
   localparam logic [63:0] INV_TWO_PI_Q32  = 64'd683565276;
   localparam logic [63:0] CORDIC_GAIN_Q32 = 64'd2608131496;
   localparam logic [63:0] US_PER_SEC      = 64'd1000000;
   localparam logic [31:0] VEL_ZERO_DT     = 32'd6554;

   // Arctangent table in binary-angle units, full turn = 2^32
   localparam logic [31:0] ATAN_BAM [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   // Status of one shared arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

### design/moi_if.sv
// Valid/ready channel interfaces of the mecanum odometry integrator.
// Depends on moi_pkg for the configuration index width.
interface moi_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] count_front_left;
   logic signed [31:0] count_front_right;
   logic signed [31:0] count_rear_left;
   logic signed [31:0] count_rear_right;
   logic        [31:0] time_stamp_us;

   modport source (output valid, count_front_left, count_front_right,
                   count_rear_left, count_rear_right, time_stamp_us,
                   input ready);
   modport sink   (input valid, count_front_left, count_front_right,
                   count_rear_left, count_rear_right, time_stamp_us,
                   output ready);
endinterface

interface moi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] pos_x;
   logic signed [63:0] pos_y;
   logic signed [31:0] heading_angle;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_turn;

   modport source (output valid, pos_x, pos_y, heading_angle, vel_x, vel_y,
                   vel_turn, input ready);
   modport sink   (input valid, pos_x, pos_y, heading_angle, vel_x, vel_y,
                   vel_turn, output ready);
endinterface

interface moi_csr_if;
   logic                          valid;
   logic                          ready;
   logic [moi_pkg::CSR_IDX_W-1:0] index;
   logic [31:0]                   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### design/moi_mul.sv
// Shared 64x64 unsigned multiplier built from four 32x32 partial products.
// Depends on moi_pkg for the unit status struct.
module moi_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [63:0]           op_a,
   input  logic [63:0]           op_b,
   output logic [127:0]          prod,
   output moi_pkg::unit_sts_type sts
);
   import moi_pkg::*;

   logic [2:0]   cnt_ff;
   logic         busy_ff;
   logic         pv_ff;
   logic [1:0]   sel_ff;
   logic [63:0]  pp_ff;
   logic [127:0] acc_ff;
   logic         done_ff;
   logic [31:0]  a_part;
   logic [31:0]  b_part;
   logic [127:0] pp_sh;

   // Pick the halves for this partial product
   assign a_part = cnt_ff[1] ? op_a[63:32] : op_a[31:0];
   assign b_part = cnt_ff[0] ? op_b[63:32] : op_b[31:0];

   // Align the registered partial product
   always_comb begin
      case (2'(sel_ff[1]) + 2'(sel_ff[0]))
         2'd0:    pp_sh = {64'd0, pp_ff};
         2'd1:    pp_sh = {32'd0, pp_ff, 32'd0};
         2'd2:    pp_sh = {pp_ff, 64'd0};
         default: pp_sh = '0;
      endcase
   end

   // Register each partial product, then accumulate it in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && cnt_ff[2];
         if (start) begin
            busy_ff <= 1'b1;
            pv_ff   <= 1'b0;
            cnt_ff  <= '0;
            acc_ff  <= '0;
         end else if (busy_ff) begin
            if (pv_ff) acc_ff <= acc_ff + pp_sh;
            if (!cnt_ff[2]) begin
               pp_ff  <= a_part * b_part;
               sel_ff <= cnt_ff[1:0];
               pv_ff  <= 1'b1;
               cnt_ff <= cnt_ff + 3'd1;
            end else begin
               pv_ff   <= 1'b0;
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign prod     = acc_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
endmodule

### design/moi_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on moi_pkg for the unit status struct.
module moi_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [63:0]           num,
   input  logic [31:0]           den,
   output logic [63:0]           quo,
   output moi_pkg::unit_sts_type sts
);
   import moi_pkg::*;

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [31:0] rem_ff;
   logic [63:0] quo_ff;
   logic [31:0] den_ff;
   logic [32:0] trial;
   logic [32:0] diff;
   logic        ge;

   // Try subtracting the divisor from the shifted remainder
   assign trial = {rem_ff, quo_ff[63]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= num;
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[31:0] : trial[31:0];
            quo_ff <= {quo_ff[62:0], ge};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quo      = quo_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
endmodule

### design/moi_cordic.sv
// Iterative rotation-mode CORDIC on 64-bit vectors with a binary angle.
// Depends on moi_pkg for the arctangent table and the unit status struct.
module moi_cordic #(
   parameter int STEPS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [63:0]    x_in,
   input  logic signed [63:0]    y_in,
   input  logic        [31:0]    z_in,
   output logic signed [63:0]    x_out,
   output logic signed [63:0]    y_out,
   output moi_pkg::unit_sts_type sts
);
   import moi_pkg::*;

   logic               busy_ff;
   logic               done_ff;
   logic [4:0]         idx_ff;
   logic signed [63:0] x_ff;
   logic signed [63:0] y_ff;
   logic        [31:0] z_ff;
   logic signed [63:0] xs;
   logic signed [63:0] ys;
   logic               flip;
   logic               dir;

   // Fold the left half turn onto the right one
   assign flip = z_in[31] ^ z_in[30];
   assign dir  = !z_ff[31];
   assign xs   = x_ff >>> idx_ff;
   assign ys   = y_ff >>> idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
            x_ff    <= flip ? -x_in : x_in;
            y_ff    <= flip ? -y_in : y_in;
            z_ff    <= flip ? z_in + 32'h8000_0000 : z_in;
         end else if (busy_ff) begin
            // Rotate toward zero residual angle
            x_ff   <= dir ? x_ff - ys : x_ff + ys;
            y_ff   <= dir ? y_ff + xs : y_ff - xs;
            z_ff   <= dir ? z_ff - ATAN_BAM[idx_ff] : z_ff + ATAN_BAM[idx_ff];
            idx_ff <= idx_ff + 5'd1;
            if (idx_ff == 5'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign x_out    = x_ff;
   assign y_out    = y_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
endmodule

### design/mecanum_odometry_integrator.sv
// Mecanum wheel odometry integrator: sequencer over a shared multiplier,
// a bit-serial divider and an iterative CORDIC.
// Per item: nine multiplies and the CORDIC rotation, then, if time has passed,
// three velocity multiplies, each followed by a divide unless it overflows.
// One item at a time; a held result stalls the input. Synchronous active-high
// reset restores the configuration and clears the control and running state.
module mecanum_odometry_integrator #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic      clock,
   input  logic      reset,
   moi_req_if.sink   req,
   moi_rsp_if.source rsp,
   moi_csr_if.sink   csr
);
   import moi_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MUL_GO   = 3'd1;
   localparam logic [2:0] ST_MUL_WAIT = 3'd2;
   localparam logic [2:0] ST_DIV_GO   = 3'd3;
   localparam logic [2:0] ST_DIV_WAIT = 3'd4;
   localparam logic [2:0] ST_ROT_GO   = 3'd5;
   localparam logic [2:0] ST_ROT_WAIT = 3'd6;
   localparam logic [2:0] ST_DONE     = 3'd7;

   localparam logic [3:0] OP_KX   = 4'd0;
   localparam logic [3:0] OP_DX   = 4'd1;
   localparam logic [3:0] OP_KY   = 4'd2;
   localparam logic [3:0] OP_DY   = 4'd3;
   localparam logic [3:0] OP_KT   = 4'd4;
   localparam logic [3:0] OP_DTH  = 4'd5;
   localparam logic [3:0] OP_GX   = 4'd6;
   localparam logic [3:0] OP_GY   = 4'd7;
   localparam logic [3:0] OP_DBAM = 4'd8;
   localparam logic [3:0] OP_VX   = 4'd9;
   localparam logic [3:0] OP_VY   = 4'd10;
   localparam logic [3:0] OP_VT   = 4'd11;

   localparam logic [1:0] SH_34 = 2'd0;
   localparam logic [1:0] SH_25 = 2'd1;
   localparam logic [1:0] SH_32 = 2'd2;

   // Configuration and persistent state
   logic [31:0]        scale_x_ff, scale_y_ff, mpt_ff, ibw_ff;
   logic [31:0]        last_ff [4];
   logic [31:0]        last_time_ff;
   logic [63:0]        acc_x_ff, acc_y_ff;
   logic [31:0]        heading_ff;

   // Per-item working registers
   logic [2:0]         state_ff;
   logic [3:0]         op_ff;
   logic signed [33:0] s_ff, t_ff;
   logic [31:0]        dt_ff;
   logic [63:0]        kx_ff, ky_ff, kt_ff;
   logic signed [63:0] dx_ff, dy_ff, dth_ff, gx_ff, gy_ff;
   logic [31:0]        dbam_ff;
   logic [31:0]        vx_ff, vy_ff, vt_ff;

   // Result register
   logic               rsp_valid_ff;
   logic [63:0]        rsp_pos_x_ff, rsp_pos_y_ff;
   logic [31:0]        rsp_head_ff, rsp_vx_ff, rsp_vy_ff, rsp_vt_ff;

   // Capture-time deltas
   logic [31:0]        cnt_in [4];
   logic [31:0]        diff [4];
   logic signed [33:0] dext [4];
   logic signed [33:0] s_in, t_in;

   // Shared unit hookup
   logic               mul_start, div_start, rot_start;
   logic [63:0]        src;
   logic               src_sgn;
   logic [63:0]        mul_b;
   logic               res_neg;
   logic [1:0]         sh_sel;
   logic               a_neg;
   logic [63:0]        mag;
   logic [127:0]       prod;
   unit_sts_type       mul_sts, div_sts, rot_sts;
   logic [63:0]        quo;
   logic signed [63:0] rot_x, rot_y;

   // Product post-processing
   logic [127:0]       rnd, sum;
   logic               over;
   logic [63:0]        res_mag, res_sat;
   logic [63:0]        smul_res;
   logic               vel_over;
   logic               accept;

   assign accept = req.valid && req.ready;
   assign cnt_in[0] = req.count_front_left;
   assign cnt_in[1] = req.count_front_right;
   assign cnt_in[2] = req.count_rear_left;
   assign cnt_in[3] = req.count_rear_right;

   // Form wrapped count deltas and the wheel mixes
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         diff[i] = cnt_in[i] - last_ff[i];
         dext[i] = {{2{diff[i][31]}}, diff[i]};
      end
      s_in = dext[0] + dext[1] + dext[2] + dext[3];
      t_in = dext[1] + dext[2] - dext[0] - dext[3];
   end

   // Select multiplier operands for the current operation
   always_comb begin
      src     = '0;
      src_sgn = 1'b1;
      mul_b   = '0;
      res_neg = 1'b0;
      sh_sel  = SH_32;
      case (op_ff)
         OP_KX:   begin src = {32'd0, scale_x_ff}; src_sgn = 1'b0; mul_b = {32'd0, mpt_ff}; end
         OP_DX:   begin src = {{30{s_ff[33]}}, s_ff}; mul_b = kx_ff; sh_sel = SH_34; end
         OP_KY:   begin src = {32'd0, scale_y_ff}; src_sgn = 1'b0; mul_b = {32'd0, mpt_ff}; end
         OP_DY:   begin
            src = {{30{t_ff[33]}}, t_ff}; mul_b = ky_ff; sh_sel = SH_34; res_neg = 1'b1;
         end
         OP_KT:   begin src = {32'd0, mpt_ff}; src_sgn = 1'b0; mul_b = {32'd0, ibw_ff}; end
         OP_DTH:  begin
            src = {{30{s_ff[33]}}, s_ff}; mul_b = kt_ff; sh_sel = SH_25; res_neg = 1'b1;
         end
         OP_GX:   begin src = dx_ff;  mul_b = CORDIC_GAIN_Q32; end
         OP_GY:   begin src = dy_ff;  mul_b = CORDIC_GAIN_Q32; end
         OP_DBAM: begin src = dth_ff; mul_b = INV_TWO_PI_Q32; end
         OP_VX:   begin src = dx_ff;  mul_b = US_PER_SEC; end
         OP_VY:   begin src = dy_ff;  mul_b = US_PER_SEC; end
         OP_VT:   begin src = dth_ff; mul_b = US_PER_SEC; end
         default: begin src = '0; end
      endcase
   end

   assign a_neg = src_sgn && src[63];
   assign mag   = a_neg ? -src : src;

   // Round half away from zero, shift, cap the magnitude, reapply the sign
   always_comb begin
      case (sh_sel)
         SH_34:   rnd = 128'd1 << 33;
         SH_25:   rnd = 128'd1 << 24;
         default: rnd = 128'd1 << 31;
      endcase
      sum = prod + rnd;
      case (sh_sel)
         SH_34:   begin over = |sum[127:98]; res_mag = sum[97:34]; end
         SH_25:   begin over = |sum[127:89]; res_mag = sum[88:25]; end
         default: begin over = |sum[127:96]; res_mag = sum[95:32]; end
      endcase
      res_sat  = (over || res_mag > DELTA_LIMIT) ? DELTA_LIMIT : res_mag;
      smul_res = (a_neg ^ res_neg) ? -res_sat : res_sat;
   end

   assign vel_over = |prod[127:80];

   // Saturate a velocity quotient to Q16.16 with the sign of the delta
   function automatic logic [31:0] sat_vel(input logic [63:0] q, input logic neg);
      logic [63:0] qq;
      if (neg) begin
         qq = (q > 64'h8000_0000) ? 64'h8000_0000 : q;
         sat_vel = 32'd0 - qq[31:0];
      end else begin
         qq = (q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : q;
         sat_vel = qq[31:0];
      end
   endfunction

   assign mul_start = state_ff == ST_MUL_GO;
   assign div_start = state_ff == ST_DIV_GO;
   assign rot_start = state_ff == ST_ROT_GO;

   moi_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .op_a  (mag),   .op_b  (mul_b), .prod  (prod), .sts (mul_sts)
   );

   moi_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num   (prod[79:16]), .den (dt_ff), .quo (quo), .sts (div_sts)
   );

   moi_cordic #(.STEPS (CORDIC_STEPS)) u_cordic (
      .clock (clock), .reset (reset), .start (rot_start),
      .x_in  (gx_ff), .y_in  (gy_ff), .z_in  (heading_ff),
      .x_out (rot_x), .y_out (rot_y), .sts   (rot_sts)
   );

   // Configuration writes
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff <= RST_SCALE_X;
         scale_y_ff <= RST_SCALE_Y;
         mpt_ff     <= RST_METERS_PER_TICK;
         ibw_ff     <= RST_INV_BASE_WIDTH;
      end else if (csr.valid) begin
         case (csr.index)
            REG_SCALE_X:         scale_x_ff <= csr.data;
            REG_SCALE_Y:         scale_y_ff <= csr.data;
            REG_METERS_PER_TICK: mpt_ff     <= csr.data;
            REG_INV_BASE_WIDTH:  ibw_ff     <= csr.data;
            default:             ;
         endcase
      end
   end

   // Sequence the operations of one item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_KX;
         for (int i = 0; i < 4; i++) last_ff[i] <= '0;
         last_time_ff <= '0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         heading_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && state_ff != ST_DONE) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  for (int i = 0; i < 4; i++) last_ff[i] <= cnt_in[i];
                  s_ff         <= s_in;
                  t_ff         <= t_in;
                  dt_ff        <= req.time_stamp_us - last_time_ff;
                  last_time_ff <= req.time_stamp_us;
                  op_ff        <= OP_KX;
                  state_ff     <= ST_MUL_GO;
               end
            end
            ST_MUL_GO: state_ff <= ST_MUL_WAIT;
            ST_MUL_WAIT: begin
               if (mul_sts.done) begin
                  op_ff    <= op_ff + 4'd1;
                  state_ff <= ST_MUL_GO;
                  case (op_ff)
                     OP_KX:   kx_ff  <= prod[63:0];
                     OP_DX:   dx_ff  <= smul_res;
                     OP_KY:   ky_ff  <= prod[63:0];
                     OP_DY:   dy_ff  <= smul_res;
                     OP_KT:   kt_ff  <= prod[63:0];
                     OP_DTH:  dth_ff <= smul_res;
                     OP_GX:   gx_ff  <= smul_res;
                     OP_GY:   gy_ff  <= smul_res;
                     OP_DBAM: begin
                        dbam_ff  <= smul_res[31:0];
                        op_ff    <= op_ff;
                        state_ff <= ST_ROT_GO;
                     end
                     default: begin
                        // Velocity: divide unless the product already overflows
                        if (vel_over) begin
                           case (op_ff)
                              OP_VX:   vx_ff <= sat_vel('1, a_neg);
                              OP_VY:   vy_ff <= sat_vel('1, a_neg);
                              default: vt_ff <= sat_vel('1, a_neg);
                           endcase
                           if (op_ff == OP_VT) state_ff <= ST_DONE;
                        end else begin
                           op_ff    <= op_ff;
                           state_ff <= ST_DIV_GO;
                        end
                     end
                  endcase
               end
            end
            ST_DIV_GO: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (div_sts.done) begin
                  op_ff    <= op_ff + 4'd1;
                  state_ff <= ST_MUL_GO;
                  case (op_ff)
                     OP_VX:   vx_ff <= sat_vel(quo, a_neg);
                     OP_VY:   vy_ff <= sat_vel(quo, a_neg);
                     default: begin
                        vt_ff    <= sat_vel(quo, a_neg);
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_ROT_GO: state_ff <= ST_ROT_WAIT;
            ST_ROT_WAIT: begin
               if (rot_sts.done) begin
                  acc_x_ff   <= acc_x_ff + rot_x;
                  acc_y_ff   <= acc_y_ff + rot_y;
                  heading_ff <= heading_ff + dbam_ff;
                  if (dt_ff == '0) begin
                     vx_ff    <= VEL_ZERO_DT;
                     vy_ff    <= 32'd0 - VEL_ZERO_DT;
                     vt_ff    <= VEL_ZERO_DT;
                     state_ff <= ST_DONE;
                  end else begin
                     op_ff    <= OP_VX;
                     state_ff <= ST_MUL_GO;
                  end
               end
            end
            ST_DONE: begin
               // Hold until the result register is free
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_pos_x_ff <= acc_x_ff;
                  rsp_pos_y_ff <= acc_y_ff;
                  rsp_head_ff  <= heading_ff;
                  rsp_vx_ff    <= vx_ff;
                  rsp_vy_ff    <= vy_ff;
                  rsp_vt_ff    <= vt_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req.ready         = state_ff == ST_IDLE;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.pos_x         = rsp_pos_x_ff;
   assign rsp.pos_y         = rsp_pos_y_ff;
   assign rsp.heading_angle = rsp_head_ff;
   assign rsp.vel_x         = rsp_vx_ff;
   assign rsp.vel_y         = rsp_vy_ff;
   assign rsp.vel_turn      = rsp_vt_ff;

   // Sequencer and shared units stay in step
   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_sts.busy)
      else $error("multiplier restarted while busy");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside its wait state");
   a_rot_wait: assert property (@(posedge clock) disable iff (reset)
      rot_sts.done |-> state_ff == ST_ROT_WAIT)
      else $error("cordic finished outside its wait state");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready)
      else $error("second transfer taken while an item is in work");
endmodule
